// ===== design/bfa_pkg.sv =====
// Shared types, codes and constants of the bitmap first-free allocator.
`default_nettype none

package bfa_pkg;

	localparam int MAX_ENTRIES_DEF = 8192;
	localparam int NUM_W = 14;
	localparam int WORD_W = 32;

	localparam logic [NUM_W-1:0] ENTRY_COUNT_RST = 14'd8192;

	// request opcodes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_RANGE  = 2'd2,
		ST_DOUBLE = 2'd3
	} status_t;

	typedef logic [NUM_W-1:0] num_t;

	// controller -> datapath
	typedef struct packed {
		logic    clr_wr;
		logic    start_alloc;
		logic    start_free;
		logic    scan;
		logic    commit_alloc;
		logic    commit_free;
		logic    set_res;
		status_t res_status;
		logic    load_out;
	} bfa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic none_active;
		logic range_bad;
		logic rd_valid;
		logic last_word;
		logic found;
		logic mark_set;
	} bfa_sts_t;

endpackage

`default_nettype wire

// ===== design/bfa_if.sv =====
// Request and response channel interfaces of the allocator.
`default_nettype none

interface bfa_req_if;
	logic          valid;
	logic          ready;
	logic          cmd;
	bfa_pkg::num_t free_number;

	modport source (output valid, output cmd, output free_number, input ready);
	modport sink (input valid, input cmd, input free_number, output ready);
endinterface

interface bfa_rsp_if;
	logic             valid;
	logic             ready;
	bfa_pkg::num_t    alloc_number;
	bfa_pkg::status_t status;
	bfa_pkg::num_t    free_count;

	modport source (output valid, output alloc_number, output status, output free_count,
		input ready);
	modport sink (input valid, input alloc_number, input status, input free_count,
		output ready);
endinterface

`default_nettype wire

// ===== design/bfa_datapath.sv =====
// Allocator datapath: bitmap memory, scan pipeline, counters and result registers.
`default_nettype none

module bfa_datapath #(
	parameter int MAX_ENTRIES = bfa_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire bfa_pkg::num_t     cfg_wr_data,
	input  wire bfa_pkg::num_t     free_number,
	input  wire bfa_pkg::bfa_cmd_t cmd,
	output bfa_pkg::bfa_sts_t      sts,
	output bfa_pkg::num_t          alloc_number,
	output bfa_pkg::status_t       status,
	output bfa_pkg::num_t          free_count
);

	localparam int WW = bfa_pkg::WORD_W;
	localparam int NW = bfa_pkg::NUM_W;
	localparam int MAP_WORDS = (MAX_ENTRIES + WW - 1) / WW;
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	logic [WW-1:0] map_mem [MAP_WORDS];

	bfa_pkg::num_t    entry_count_q;
	bfa_pkg::num_t    used_q;
	logic [AW-1:0]    w_q;
	logic             issue_q;
	logic [AW-1:0]    clr_q;
	logic [4:0]       bit_q;
	logic [WW-1:0]    rd_s1;
	logic [AW-1:0]    rdw_s1;
	logic             rdv_s1;
	bfa_pkg::num_t    res_alloc_q;
	bfa_pkg::status_t res_status_q;
	bfa_pkg::num_t    out_alloc_q;
	bfa_pkg::status_t out_status_q;
	bfa_pkg::num_t    out_free_q;

	bfa_pkg::num_t active_n;
	bfa_pkg::num_t n_m1;
	bfa_pkg::num_t num_m1;
	logic [31:0]   last32;
	logic [31:0]   fw32;
	logic [AW-1:0] last_w;
	logic [AW-1:0] free_w;
	logic [5:0]    tail;
	logic [32:0]   tail_mask;
	logic [WW-1:0] vmask;
	logic [WW-1:0] avail;
	logic [4:0]    pos;
	logic [31:0]   entry32;
	bfa_pkg::num_t alloc_num;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [WW-1:0] wr_data;

	// active count is the register clipped to the bitmap size
	always_comb begin
		active_n = (32'(entry_count_q) > 32'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : entry_count_q;
		n_m1 = active_n - NW'(1);
		num_m1 = free_number - NW'(1);
		last32 = 32'(n_m1 >> 5);
		fw32 = 32'(num_m1 >> 5);
		last_w = last32[AW-1:0];
		free_w = fw32[AW-1:0];
		tail = 6'(n_m1[4:0]) + 6'd1;
		tail_mask = (33'd1 << tail) - 33'd1;
		vmask = (rdw_s1 == last_w) ? tail_mask[WW-1:0] : '1;
		avail = ~rd_s1 & vmask;
	end

	// lowest free bit of the word under test
	always_comb begin
		pos = '0;
		for (int i = WW - 1; i >= 0; i--) begin
			if (avail[i]) begin
				pos = 5'(i);
			end
		end
		entry32 = (32'(rdw_s1) << 5) | 32'(pos);
		alloc_num = NW'(entry32 + 32'd1);
	end

	always_comb begin
		sts.clr_last = (clr_q == AW'(MAP_WORDS - 1));
		sts.none_active = (active_n == '0);
		sts.range_bad = (free_number == '0) || (free_number > active_n);
		sts.rd_valid = rdv_s1;
		sts.last_word = (rdw_s1 == last_w);
		sts.found = rdv_s1 && (|avail);
		sts.mark_set = rd_s1[bit_q];
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = rdw_s1;
		wr_data = rd_s1;
		if (cmd.clr_wr) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (cmd.commit_alloc) begin
			wr_en = 1'b1;
			wr_data = rd_s1 | (WW'(1) << pos);
		end else if (cmd.commit_free) begin
			wr_en = 1'b1;
			wr_data = rd_s1 & ~(WW'(1) << bit_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		rd_s1 <= map_mem[w_q];
		rdw_s1 <= w_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= bfa_pkg::ENTRY_COUNT_RST;
			used_q <= '0;
			w_q <= '0;
			issue_q <= 1'b0;
			clr_q <= '0;
			bit_q <= '0;
			rdv_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				entry_count_q <= cfg_wr_data;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			rdv_s1 <= cmd.scan && issue_q;
			if (cmd.start_alloc) begin
				w_q <= '0;
				issue_q <= 1'b1;
			end else if (cmd.start_free) begin
				w_q <= free_w;
				bit_q <= num_m1[4:0];
			end else if (cmd.scan && issue_q) begin
				if (w_q == last_w) begin
					issue_q <= 1'b0;
				end else begin
					w_q <= w_q + AW'(1);
				end
			end
			if (cmd.commit_alloc) begin
				used_q <= used_q + NW'(1);
			end else if (cmd.commit_free && used_q != '0) begin
				used_q <= used_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit_alloc) begin
			res_alloc_q <= alloc_num;
			res_status_q <= bfa_pkg::ST_OK;
		end else if (cmd.commit_free) begin
			res_alloc_q <= '0;
			res_status_q <= bfa_pkg::ST_OK;
		end else if (cmd.set_res) begin
			res_alloc_q <= '0;
			res_status_q <= cmd.res_status;
		end
		if (cmd.load_out) begin
			out_alloc_q <= res_alloc_q;
			out_status_q <= res_status_q;
			out_free_q <= (active_n > used_q) ? active_n - used_q : '0;
		end
	end

	assign alloc_number = out_alloc_q;
	assign status = out_status_q;
	assign free_count = out_free_q;

endmodule

`default_nettype wire

// ===== design/bfa_ctrl.sv =====
// Allocator controller: clearing pass, request sequencing and response handshake.
`default_nettype none

module bfa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic              req_cmd,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	input  wire bfa_pkg::bfa_sts_t sts,
	output bfa_pkg::bfa_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC,
		S_FREE_RD,
		S_FREE_CHK,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		req_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					if (req_cmd == bfa_pkg::CMD_ALLOC) begin
						if (sts.none_active) begin
							cmd.set_res = 1'b1;
							cmd.res_status = bfa_pkg::ST_FULL;
							state_d = S_DONE;
						end else begin
							cmd.start_alloc = 1'b1;
							state_d = S_ALLOC;
						end
					end else if (sts.range_bad) begin
						cmd.set_res = 1'b1;
						cmd.res_status = bfa_pkg::ST_RANGE;
						state_d = S_DONE;
					end else begin
						cmd.start_free = 1'b1;
						state_d = S_FREE_RD;
					end
				end
			end
			S_ALLOC: begin
				cmd.scan = 1'b1;
				if (sts.found) begin
					cmd.commit_alloc = 1'b1;
					state_d = S_DONE;
				end else if (sts.rd_valid && sts.last_word) begin
					cmd.set_res = 1'b1;
					cmd.res_status = bfa_pkg::ST_FULL;
					state_d = S_DONE;
				end
			end
			S_FREE_RD: begin
				state_d = S_FREE_CHK;
			end
			S_FREE_CHK: begin
				if (sts.mark_set) begin
					cmd.commit_free = 1'b1;
				end else begin
					cmd.set_res = 1'b1;
					cmd.res_status = bfa_pkg::ST_DOUBLE;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				// move into the output register once it is free
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= cmd.load_out || (out_valid_q && !rsp_ready);
		end
	end

	assign rsp_valid = out_valid_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while previous request in flight");

	a_alloc_needs_free_bit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_alloc |-> sts.found)
		else $error("allocation committed without a free mark");

	a_free_needs_set_mark: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_free |-> sts.mark_set)
		else $error("free committed on a clear mark");

endmodule

`default_nettype wire

// ===== design/bitmap_first_free_allocator_top.sv =====
// Top level of the bitmap first-free allocator.
//
//  channel  dir  handshake          payload
//  req      in   req.valid/ready    cmd, free_number
//  rsp      out  rsp.valid/ready    alloc_number, status, free_count
//  cfg      in   cfg_wr_en          cfg_wr_data (entry_count)
//
// After reset a clearing pass zeroes the bitmap, one 32-bit word a cycle, over all
// ceil(MAX_ENTRIES/32) words (256 at the default); no request is taken then.
// An allocate reads bitmap words in order until the first free mark, one word per
// cycle through the single read port, up to ceil(min(entry_count, MAX_ENTRIES)/32)
// words. One request is in flight at a time; a finished response waits in the
// output register while a new request is accepted.
`default_nettype none

module bitmap_first_free_allocator_top #(
	parameter int MAX_ENTRIES = bfa_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_wr_en,
	input  wire bfa_pkg::num_t cfg_wr_data,
	bfa_req_if.sink            req,
	bfa_rsp_if.source          rsp
);

	bfa_pkg::bfa_cmd_t cmd;
	bfa_pkg::bfa_sts_t sts;

	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_cmd   (req.cmd),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bfa_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.free_number  (req.free_number),
		.cmd          (cmd),
		.sts          (sts),
		.alloc_number (rsp.alloc_number),
		.status       (rsp.status),
		.free_count   (rsp.free_count)
	);

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the bitmap first-free allocator.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = bfa_pkg::MAX_ENTRIES_DEF;
	localparam int LIMIT_NS = 8_000_000;
	localparam int TAIL_CYCLES = 300;

	typedef struct packed {
		bfa_pkg::num_t    alloc_number;
		bfa_pkg::status_t status;
		bfa_pkg::num_t    free_count;
	} grant_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          cfg_wr_en;
	bfa_pkg::num_t cfg_wr_data;

	bfa_req_if req_ch ();
	bfa_rsp_if rsp_ch ();

	bitmap_first_free_allocator_top #(
		.MAX_ENTRIES(SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// predictor state
	bit     in_use [SLOTS];
	int     in_use_total;
	int     entry_limit;

	grant_t owed[$];
	bit     pace;
	int     errors;
	int     sent;
	int     by_status [4];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int active_span();
		return (entry_limit > SLOTS) ? SLOTS : entry_limit;
	endfunction

	// first-fit allocate or release, updates the shadow bitmap
	function automatic void serve(input logic op, input bfa_pkg::num_t num, output grant_t g);
		int  span;
		int  i;
		bit  found;
		span = active_span();
		g.alloc_number = '0;
		g.status = bfa_pkg::ST_OK;
		if (op == bfa_pkg::CMD_ALLOC) begin
			found = 1'b0;
			for (i = 0; i < span && !found; i++) begin
				if (!in_use[i]) begin
					in_use[i] = 1'b1;
					in_use_total++;
					g.alloc_number = bfa_pkg::num_t'(i + 1);
					found = 1'b1;
				end
			end
			if (!found)
				g.status = bfa_pkg::ST_FULL;
		end else if (num == 0 || int'(num) > span) begin
			g.status = bfa_pkg::ST_RANGE;
		end else if (!in_use[num - 1]) begin
			g.status = bfa_pkg::ST_DOUBLE;
		end else begin
			in_use[num - 1] = 1'b0;
			if (in_use_total > 0)
				in_use_total--;
		end
		g.free_count = (span > in_use_total) ? bfa_pkg::num_t'(span - in_use_total) : '0;
	endfunction

	// 1-based number of a mark in the active span with the wanted value, 0 if none
	function automatic bfa_pkg::num_t pick_mark(input bit want_set);
		int span;
		int start;
		int k;
		int idx;
		span = active_span();
		if (span == 0)
			return '0;
		start = $urandom_range(0, span - 1);
		for (k = 0; k < span; k++) begin
			idx = (start + k) % span;
			if (in_use[idx] == want_set)
				return bfa_pkg::num_t'(idx + 1);
		end
		return '0;
	endfunction

	function automatic void flag(input string what, input int want, input int got);
		errors++;
		$display("%0t tb: %s mismatch, expected %0d got %0d", $time, what, want, got);
	endfunction

	task automatic send_request(input logic op, input bfa_pkg::num_t num);
		int     gap;
		grant_t g;
		gap = pace ? gap_len() : 0;
		if (gap != 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.cmd = op;
		req_ch.free_number = num;
		req_ch.valid = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		serve(op, num, g);
		owed.push_back(g);
		sent++;
		@(negedge clk);
	endtask

	task automatic alloc_one();
		send_request(bfa_pkg::CMD_ALLOC, bfa_pkg::num_t'($urandom_range(0, 16383)));
	endtask

	task automatic drain();
		req_ch.valid = 1'b0;
		while (owed.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_entry_count(input bfa_pkg::num_t value);
		drain();
		cfg_wr_en = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		entry_limit = value;
	endtask

	task automatic test_reset_defaults();
		pace = 1'b1;
		alloc_one();
		send_request(bfa_pkg::CMD_FREE, 14'd0);
		send_request(bfa_pkg::CMD_FREE, 14'd8193);
		send_request(bfa_pkg::CMD_FREE, 14'h3FFF);
		send_request(bfa_pkg::CMD_FREE, 14'd2);
		send_request(bfa_pkg::CMD_FREE, 14'd1);
		send_request(bfa_pkg::CMD_FREE, 14'd8192);
		drain();
	endtask

	task automatic test_fill_to_full();
		write_entry_count(14'd8);
		repeat (9) alloc_one();
		send_request(bfa_pkg::CMD_FREE, 14'd3);
		alloc_one();
		drain();
	endtask

	// marks above the new count stay used; free count saturates at zero
	task automatic test_limit_lowered();
		write_entry_count(14'd3);
		alloc_one();
		send_request(bfa_pkg::CMD_FREE, 14'd5);
		send_request(bfa_pkg::CMD_FREE, 14'd2);
		write_entry_count(14'd8);
		alloc_one();
		drain();
	endtask

	task automatic test_zero_limit();
		write_entry_count(14'd0);
		alloc_one();
		send_request(bfa_pkg::CMD_FREE, 14'd1);
		drain();
	endtask

	task automatic test_wide_limits();
		write_entry_count(14'h3FFF);
		alloc_one();
		send_request(bfa_pkg::CMD_FREE, 14'd8192);
		write_entry_count(14'd1);
		send_request(bfa_pkg::CMD_FREE, 14'd1);
		alloc_one();
		alloc_one();
		drain();
	endtask

	task automatic run_mix(input bfa_pkg::num_t limit, input int n, input int alloc_pct,
		input bit paced);
		int            i;
		int            r;
		bfa_pkg::num_t pick;
		write_entry_count(limit);
		pace = paced;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < alloc_pct) begin
				alloc_one();
			end else begin
				r = $urandom_range(0, 9);
				if (r < 7)
					pick = pick_mark(1'b1);
				else if (r < 8)
					pick = pick_mark(1'b0);
				else
					pick = bfa_pkg::num_t'($urandom_range(0, 16383));
				if (r < 8 && pick == 0)
					alloc_one();
				else
					send_request(bfa_pkg::CMD_FREE, pick);
			end
		end
		drain();
		pace = 1'b1;
	endtask

	task automatic test_random_mix();
		run_mix(14'd33, 150, 55, 1'b1);
		run_mix(14'd64, 120, 45, 1'b0);
		run_mix(14'd200, 120, 70, 1'b1);
		run_mix(14'd8192, 130, 80, 1'b1);
		run_mix(bfa_pkg::num_t'($urandom_range(1, 8192)), 80, 50, 1'b1);
		run_mix(14'd40, 60, 35, 1'b1);
		run_mix(bfa_pkg::num_t'($urandom_range(8193, 16383)), 40, 50, 1'b0);
	endtask

	// response side stalls
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = pace ? gap_len() : 0;
			if (stall != 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			by_status[rsp_ch.status]++;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t tb: response with none pending, expected nothing got %0d/%0d/%0d",
					$time, rsp_ch.alloc_number, rsp_ch.status, rsp_ch.free_count);
			end else begin
				want = owed.pop_front();
				if (rsp_ch.alloc_number !== want.alloc_number)
					flag("alloc_number", want.alloc_number, rsp_ch.alloc_number);
				if (rsp_ch.status !== want.status)
					flag("status", want.status, rsp_ch.status);
				if (rsp_ch.free_count !== want.free_count)
					flag("free_count", want.free_count, rsp_ch.free_count);
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("tb: timed out with %0d responses outstanding", owed.size());
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = bfa_pkg::CMD_ALLOC;
		req_ch.free_number = '0;
		pace = 1'b1;
		entry_limit = bfa_pkg::ENTRY_COUNT_RST;
		in_use_total = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_fill_to_full();
		test_limit_lowered();
		test_zero_limit();
		test_wide_limits();
		test_random_mix();

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("tb: %0d requests over entry counts 0 to 16383, stalls on both sides",
			sent);
		$display("tb: replies ok %0d, full %0d, out of range %0d, double free %0d",
			by_status[bfa_pkg::ST_OK], by_status[bfa_pkg::ST_FULL],
			by_status[bfa_pkg::ST_RANGE], by_status[bfa_pkg::ST_DOUBLE]);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
